// ===== sv/kefa_pkg.sv =====
// ----------------------------------------------------------------------------
// kefa_pkg
// Shared sizes, codes and types for the key event queue and press arbiter.
// ----------------------------------------------------------------------------
package kefa_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_LIMIT   = 64;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    // operation codes
    localparam logic [1:0] OP_HW_PUSH  = 2'd0;
    localparam logic [1:0] OP_INJ_PUSH = 2'd1;
    localparam logic [1:0] OP_POP      = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_KEY = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_BUSY    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    // one stored event, bit 7 source, bit 6 press, bits 5..0 key
    typedef struct packed {
        logic       source;
        logic       press;
        logic [5:0] key;
    } event_t;

    typedef struct packed {
        logic   wr_en;
        logic   rd_en;
        event_t wr_data;
    } queue_cmd_t;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [LVL_W-1:0] level;
    } queue_stat_t;

endpackage

// ===== sv/key_event_fifo_with_press_arbiter.sv =====
// ----------------------------------------------------------------------------
// key_event_fifo_with_press_arbiter
// Key event queue with arbitration between hardware and injected key events.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Ports                    Contents
// s_       in   s_tvalid/s_tready        requests: push (hardware/injected), pop
// m_       out  m_tvalid/m_tready        one result per request
//
// One request per cycle is sustained while the output is not stalled. A
// request is decided at the edge it is accepted; a pop reads the queue RAM
// then, and its data waits in the RAM read register while the request is in
// the pending stage. A stalled output holds the output register; the pending
// stage takes one more request, then s_tready drops.
// Reset (aresetn low, synchronous) empties the queue and clears the bitmap
// and counters; the RAM contents are left as they are.
//
module key_event_fifo_with_press_arbiter (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,  // key_code[7:0], is_press[8], zero pad
    input  logic [1:0]   s_tuser,  // operation[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata   // status[2:0], event_valid[3],
                                   // event_key[9:4], event_press[10],
                                   // event_source[11], held_mask[75:12],
                                   // queued_total[107:76],
                                   // dropped_total[139:108],
                                   // rejected_total[171:140], zero pad
);

    // request fields
    logic [1:0] operation;
    logic [7:0] key_code;
    logic       is_press;
    logic [5:0] key_idx;

    assign operation = s_tuser;
    assign key_code  = s_tdata[7:0];
    assign is_press  = s_tdata[8];
    assign key_idx   = key_code[5:0];

    // architectural state
    logic [63:0] held_reg, held_next;
    logic [31:0] enq_cnt_reg, enq_cnt_next;
    logic [31:0] drop_cnt_reg, drop_cnt_next;
    logic [31:0] rej_cnt_reg, rej_cnt_next;

    // pending stage, waits for RAM read data
    logic        pend_valid_reg;
    logic [2:0]  pend_status_reg;
    logic        pend_hit_reg;
    logic [63:0] pend_mask_reg;
    logic [31:0] pend_enq_reg;
    logic [31:0] pend_drop_reg;
    logic [31:0] pend_rej_reg;

    // output register
    logic         m_valid_reg;
    logic [175:0] m_data_reg;

    logic                  s_accept;
    logic                  pend_move;
    logic [2:0]            status_next;
    logic                  hit_next;
    logic                  key_ok;
    kefa_pkg::queue_cmd_t  q_cmd;
    kefa_pkg::queue_stat_t q_stat;
    kefa_pkg::event_t      q_rd_data;
    kefa_pkg::event_t      ev_out;

    assign pend_move = pend_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !pend_valid_reg || pend_move;
    assign s_accept  = s_tvalid && s_tready;

    assign key_ok = (key_code != 8'd0) && (key_code < 8'(kefa_pkg::KEY_LIMIT));

    // decide the request against the current state
    always_comb begin
        held_next     = held_reg;
        enq_cnt_next  = enq_cnt_reg;
        drop_cnt_next = drop_cnt_reg;
        rej_cnt_next  = rej_cnt_reg;
        status_next   = kefa_pkg::ST_OK;
        hit_next      = 1'b0;
        q_cmd.wr_en   = 1'b0;
        q_cmd.rd_en   = 1'b0;
        q_cmd.wr_data.key    = key_idx;
        q_cmd.wr_data.press  = is_press;
        q_cmd.wr_data.source = (operation == kefa_pkg::OP_INJ_PUSH);
        if (s_accept) begin
            case (operation)
                kefa_pkg::OP_HW_PUSH, kefa_pkg::OP_INJ_PUSH: begin
                    if (!key_ok) begin
                        status_next = kefa_pkg::ST_BAD_KEY;
                    end else if (operation == kefa_pkg::OP_INJ_PUSH && is_press
                                 && held_reg[key_idx]) begin
                        // hardware owns this key
                        status_next  = kefa_pkg::ST_BUSY;
                        rej_cnt_next = rej_cnt_reg + 32'd1;
                    end else begin
                        if (operation == kefa_pkg::OP_HW_PUSH) begin
                            held_next[key_idx] = is_press;
                        end
                        if (q_stat.full) begin
                            status_next   = kefa_pkg::ST_FULL;
                            drop_cnt_next = drop_cnt_reg + 32'd1;
                        end else begin
                            q_cmd.wr_en  = 1'b1;
                            enq_cnt_next = enq_cnt_reg + 32'd1;
                        end
                    end
                end
                kefa_pkg::OP_POP: begin
                    if (q_stat.empty) begin
                        status_next = kefa_pkg::ST_EMPTY;
                    end else begin
                        q_cmd.rd_en = 1'b1;
                        hit_next    = 1'b1;
                    end
                end
                default: begin
                    // unused code: no action, ok status
                end
            endcase
        end
    end

    kefa_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (q_cmd),
        .stat    (q_stat),
        .rd_data (q_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg       <= '0;
            enq_cnt_reg    <= '0;
            drop_cnt_reg   <= '0;
            rej_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            held_reg     <= held_next;
            enq_cnt_reg  <= enq_cnt_next;
            drop_cnt_reg <= drop_cnt_next;
            rej_cnt_reg  <= rej_cnt_next;
            if (s_accept) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_move) begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // snapshot of the state after this request
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_status_reg <= status_next;
            pend_hit_reg    <= hit_next;
            pend_mask_reg   <= held_next;
            pend_enq_reg    <= enq_cnt_next;
            pend_drop_reg   <= drop_cnt_next;
            pend_rej_reg    <= rej_cnt_next;
        end
    end

    // event fields read as zero when no event was popped
    assign ev_out = pend_hit_reg ? q_rd_data : '0;

    always_ff @(posedge aclk) begin
        if (pend_move) begin
            m_data_reg <= {4'd0, pend_rej_reg, pend_drop_reg, pend_enq_reg,
                           pend_mask_reg, ev_out.source, ev_out.press,
                           ev_out.key, pend_hit_reg, pend_status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_level_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.level <= kefa_pkg::LVL_W'(kefa_pkg::QUEUE_DEPTH))
        else $error("queue level beyond depth");

    a_enq_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(enq_cnt_reg))
        else $error("enqueue counter moved without a request");

    a_empty_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[2:0] == kefa_pkg::ST_EMPTY) |-> !m_data_reg[3])
        else $error("empty pop carried an event");

    a_pop_from_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cmd.rd_en |-> !q_stat.empty)
        else $error("queue read while empty");
`endif

endmodule

// ===== sv/kefa_queue.sv =====
// ----------------------------------------------------------------------------
// kefa_queue
// Circular event queue held in a synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module kefa_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kefa_pkg::queue_cmd_t  cmd,
    output kefa_pkg::queue_stat_t stat,
    output kefa_pkg::event_t      rd_data
);

    kefa_pkg::event_t mem [kefa_pkg::QUEUE_DEPTH];

    logic [kefa_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [kefa_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [kefa_pkg::LVL_W-1:0] level_reg, level_next;
    kefa_pkg::event_t           rd_data_reg;

    localparam logic [kefa_pkg::PTR_W-1:0] LAST_SLOT =
        kefa_pkg::PTR_W'(kefa_pkg::QUEUE_DEPTH - 1);

    // caller only writes when not full and reads when not empty
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (cmd.wr_en) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd.rd_en) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (cmd.wr_en && !cmd.rd_en) begin
            level_next = level_reg + 1'b1;
        end else if (cmd.rd_en && !cmd.wr_en) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_ptr_reg] <= cmd.wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_data    = rd_data_reg;
    assign stat.full  = (level_reg == kefa_pkg::LVL_W'(kefa_pkg::QUEUE_DEPTH));
    assign stat.empty = (level_reg == '0);
    assign stat.level = level_reg;

endmodule
